### rtl/sfr_pkg.sv
// package for the stream find-and-replace block
// word types, cell control/status structs, config register indexes and state codes
// no dependencies
`default_nettype none

package sfr_pkg;

    localparam int BYTE_W       = 8;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_IDX_W    = 2;
    localparam int LEN_W        = 4;
    localparam int PATTERN_MAX_DEF = 8;
    localparam int REPLACE_MAX_DEF = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_BYTES      = 2'd0,
        REG_PATTERN_LENGTH     = 2'd1,
        REG_REPLACEMENT_BYTES  = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } cfg_reg_t;

    localparam logic FUNC_CHAR = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    typedef struct packed {
        logic              func;
        logic [BYTE_W-1:0] char_byte;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_REPL
    } state_t;

    // control handed to each window cell
    typedef struct packed {
        logic              shift;
        logic              load;
        logic [BYTE_W-1:0] din;
    } cell_ctl_t;

    // what each cell reports back
    typedef struct packed {
        logic [BYTE_W-1:0] byte_val;
        logic              match_own;
        logic              match_prev;
    } cell_stat_t;

endpackage

`default_nettype wire

### rtl/sfr_cell.sv
// one slot of the pending window: holds a byte, shifts toward slot 0
// compares its byte with its own pattern byte and with the one before it
// depends on sfr_pkg
`default_nettype none

module sfr_cell (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire sfr_pkg::cell_ctl_t         ctl,
    input  wire logic [sfr_pkg::BYTE_W-1:0] right_byte,
    input  wire logic [sfr_pkg::BYTE_W-1:0] pat_own,
    input  wire logic [sfr_pkg::BYTE_W-1:0] pat_prev,
    output sfr_pkg::cell_stat_t             stat
);

    logic [sfr_pkg::BYTE_W-1:0] byte_reg;
    logic [sfr_pkg::BYTE_W-1:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctl.shift)
        begin
            byte_next = right_byte;
        end
        else if (ctl.load)
        begin
            byte_next = ctl.din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    // match_prev tells whether the window still fits once it shifts by one
    assign stat.byte_val   = byte_reg;
    assign stat.match_own  = (byte_reg == pat_own);
    assign stat.match_prev = (byte_reg == pat_prev);

endmodule

`default_nettype wire

### rtl/stream_find_and_replace.sv
// top level: config registers, window cell chain, sequencer and output register
// depends on sfr_pkg and sfr_cell
// sequence: a character word is taken in ST_IDLE and checked in ST_SCAN in the cycle after; the emitted bytes
// then go out one at a time, up to 8 per item with the default parameters
// throughput: one item at a time, one byte per cycle into the output register while the result is not stalled
// reset: window cleared, pattern 0 length 1, empty replacement, no result pending
`default_nettype none

module stream_find_and_replace #(
    parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
    parameter int REPLACE_MAX = sfr_pkg::REPLACE_MAX_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           item_valid,
    output logic                                item_ready,
    input  wire sfr_pkg::item_t                 item,
    output logic                                result_valid,
    input  wire logic                           result_ready,
    output sfr_pkg::result_t                    result
);

    localparam int BW  = sfr_pkg::BYTE_W;
    localparam int CW  = $clog2(PATTERN_MAX + 1);
    localparam int RCW = $clog2(REPLACE_MAX + 1);
    localparam int RIW = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;
    localparam logic [sfr_pkg::LEN_W-1:0] PMAX_L = sfr_pkg::LEN_W'(PATTERN_MAX);
    localparam logic [sfr_pkg::LEN_W-1:0] RMAX_L = sfr_pkg::LEN_W'(REPLACE_MAX);

    // configuration registers
    logic [PATTERN_MAX-1:0][BW-1:0] pat_reg;
    logic [REPLACE_MAX-1:0][BW-1:0] repl_reg;
    logic [sfr_pkg::LEN_W-1:0]      plen_reg;
    logic [sfr_pkg::LEN_W-1:0]      rlen_reg;

    logic                  pat_wr;
    sfr_pkg::cfg_reg_t     cfg_sel;

    assign cfg_sel = sfr_pkg::cfg_reg_t'(cfg_index);
    assign pat_wr  = cfg_we && (cfg_sel == sfr_pkg::REG_PATTERN_BYTES
                             || cfg_sel == sfr_pkg::REG_PATTERN_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg  <= '0;
            repl_reg <= '0;
            plen_reg <= sfr_pkg::LEN_W'(1);
            rlen_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_sel)
                sfr_pkg::REG_PATTERN_BYTES:      pat_reg  <= cfg_data[BW*PATTERN_MAX-1:0];
                sfr_pkg::REG_PATTERN_LENGTH:     plen_reg <= cfg_data[sfr_pkg::LEN_W-1:0];
                sfr_pkg::REG_REPLACEMENT_BYTES:  repl_reg <= cfg_data[BW*REPLACE_MAX-1:0];
                sfr_pkg::REG_REPLACEMENT_LENGTH: rlen_reg <= cfg_data[sfr_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped lengths
    logic [CW-1:0]  plen_eff;
    logic [RCW-1:0] rlen_eff;

    always_comb
    begin
        if (plen_reg == '0)
        begin
            plen_eff = CW'(1);
        end
        else if (plen_reg > PMAX_L)
        begin
            plen_eff = CW'(PATTERN_MAX);
        end
        else
        begin
            plen_eff = CW'(plen_reg);
        end

        if (rlen_reg > RMAX_L)
        begin
            rlen_eff = RCW'(REPLACE_MAX);
        end
        else
        begin
            rlen_eff = RCW'(rlen_reg);
        end
    end

    // sequencer state
    sfr_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [RIW-1:0]  rep_idx_reg, rep_idx_next;
    logic            out_valid_reg, out_valid_next;
    sfr_pkg::result_t out_word_reg, out_word_next;

    // cell chain
    sfr_pkg::cell_ctl_t  ctl  [PATTERN_MAX];
    sfr_pkg::cell_stat_t stat [PATTERN_MAX];
    logic                load_en;
    logic                shift_en;

    genvar g;
    generate
        for (g = 0; g < PATTERN_MAX; g++)
        begin : g_cell
            logic [BW-1:0] right_byte;
            logic [BW-1:0] pat_prev;

            if (g < PATTERN_MAX - 1)
            begin : g_mid
                assign right_byte = stat[g+1].byte_val;
            end
            else
            begin : g_end
                assign right_byte = '0;
            end

            if (g > 0)
            begin : g_prev
                assign pat_prev = pat_reg[g-1];
            end
            else
            begin : g_first
                assign pat_prev = pat_reg[0];
            end

            assign ctl[g].shift = shift_en;
            assign ctl[g].load  = load_en && (count_reg == CW'(g));
            assign ctl[g].din   = item.char_byte;

            sfr_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl[g]),
                .right_byte (right_byte),
                .pat_own    (pat_reg[g]),
                .pat_prev   (pat_prev),
                .stat       (stat[g])
            );
        end
    endgenerate

    // prefix checks over the occupied cells, now and after one shift
    logic is_prefix;
    logic shift_prefix;

    always_comb
    begin
        is_prefix    = 1'b1;
        shift_prefix = 1'b1;
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            if (CW'(k) < count_reg && !stat[k].match_own)
            begin
                is_prefix = 1'b0;
            end
            if (k > 0 && CW'(k) < count_reg && !stat[k].match_prev)
            begin
                shift_prefix = 1'b0;
            end
        end
    end

    logic out_free;
    assign out_free   = !out_valid_reg || result_ready;
    assign item_ready = (state_reg == sfr_pkg::ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rep_idx_next   = rep_idx_reg;
        load_en        = 1'b0;
        shift_en       = 1'b0;
        out_valid_next = out_valid_reg && !result_ready;
        out_word_next  = out_word_reg;

        case (state_reg)
            sfr_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.func == sfr_pkg::FUNC_END)
                    begin
                        if (count_reg != '0)
                        begin
                            state_next = sfr_pkg::ST_FLUSH;
                        end
                    end
                    else
                    begin
                        load_en    = 1'b1;
                        count_next = count_reg + CW'(1);
                        state_next = sfr_pkg::ST_SCAN;
                    end
                end
            end

            sfr_pkg::ST_SCAN:
            begin
                if (!is_prefix)
                begin
                    // oldest byte can no longer start a match
                    if (out_free)
                    begin
                        shift_en                = 1'b1;
                        count_next              = count_reg - CW'(1);
                        out_valid_next          = 1'b1;
                        out_word_next.out_byte  = stat[0].byte_val;
                        out_word_next.last      = shift_prefix;
                    end
                end
                else if (count_reg == plen_eff)
                begin
                    count_next   = '0;
                    rep_idx_next = '0;
                    if (rlen_eff == '0)
                    begin
                        state_next = sfr_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = sfr_pkg::ST_REPL;
                    end
                end
                else
                begin
                    state_next = sfr_pkg::ST_IDLE;
                end
            end

            sfr_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    shift_en               = 1'b1;
                    count_next             = count_reg - CW'(1);
                    out_valid_next         = 1'b1;
                    out_word_next.out_byte = stat[0].byte_val;
                    out_word_next.last     = (count_reg == CW'(1));
                    if (count_reg == CW'(1))
                    begin
                        state_next = sfr_pkg::ST_IDLE;
                    end
                end
            end

            sfr_pkg::ST_REPL:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_word_next.out_byte = repl_reg[rep_idx_reg];
                    out_word_next.last     = (RCW'(rep_idx_reg) + RCW'(1) == rlen_eff);
                    rep_idx_next           = rep_idx_reg + RIW'(1);
                    if (RCW'(rep_idx_reg) + RCW'(1) == rlen_eff)
                    begin
                        state_next = sfr_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = sfr_pkg::ST_IDLE;
            end
        endcase

        // a pattern change drops the pending window bytes
        if (pat_wr)
        begin
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sfr_pkg::ST_IDLE;
            count_reg     <= '0;
            rep_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rep_idx_reg   <= rep_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

endmodule

`default_nettype wire

### rtl/sfr_checker.sv
// port-level checks for the stream find-and-replace block, bound to the top level
// depends on sfr_pkg and stream_find_and_replace
`default_nettype none

module sfr_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           cfg_we,
    input wire logic                           item_valid,
    input wire logic                           item_ready,
    input wire sfr_pkg::item_t                 item,
    input wire logic                           result_valid,
    input wire logic                           result_ready,
    input wire sfr_pkg::result_t               result
);

    // a stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

    // more bytes of this item to come, so no new item may enter
    a_busy_until_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> !item_ready)
    else $error("item taken before last word of previous item");

    // a character word always goes through a check in ST_SCAN before the next item is taken
    a_char_check: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.func == sfr_pkg::FUNC_CHAR |=> !item_ready)
    else $error("ready stayed high after a character word");

    // register writes must land only while idle; the block leaves this rule to the user
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> item_ready)
    else $error("register written while block busy");

endmodule

bind stream_find_and_replace sfr_checker u_sfr_checker (.*);

`default_nettype wire

### sim/tb_stream_find_and_replace.sv
// testbench for stream_find_and_replace: directed and random text against a byte-level predictor
// depends on sfr_pkg and the rtl of stream_find_and_replace
// scoreboard class predicts the emitted words; plain tasks drive text, end words and registers
`timescale 1ns / 1ps

module tb_stream_find_and_replace;

    localparam int CYCLE_LIMIT = 400000;
    // item latency plus the longest run of emitted bytes
    localparam int IDLE_GAP    = 12;

    class replace_scoreboard;
        logic [63:0] pattern_word;
        logic [3:0]  pattern_len;
        logic [63:0] repl_word;
        logic [3:0]  repl_len;
        logic [7:0]  window [8];
        int          window_fill;
        sfr_pkg::result_t expected_bytes [$];
        int          errors;

        function new();
            pattern_word = '0;
            pattern_len  = 4'd1;
            repl_word    = '0;
            repl_len     = 4'd0;
            window_fill  = 0;
            errors       = 0;
        endfunction

        function int pattern_width();
            if (pattern_len == 4'd0)
                return 1;
            if (pattern_len > 4'd8)
                return 8;
            return int'(pattern_len);
        endfunction

        function void load_reg(sfr_pkg::cfg_reg_t idx, logic [63:0] data);
            case (idx)
                sfr_pkg::REG_PATTERN_BYTES:
                begin
                    pattern_word = data;
                    window_fill  = 0;
                end
                sfr_pkg::REG_PATTERN_LENGTH:
                begin
                    pattern_len = data[3:0];
                    window_fill = 0;
                end
                sfr_pkg::REG_REPLACEMENT_BYTES:  repl_word = data;
                sfr_pkg::REG_REPLACEMENT_LENGTH: repl_len  = data[3:0];
                default: ;
            endcase
        endfunction

        // works out the bytes one accepted input word emits
        function void note_item(sfr_pkg::item_t it);
            logic [7:0] emitted [$];
            logic       is_prefix;
            int         plen;
            int         rlen;
            sfr_pkg::result_t r;
            if (it.func == sfr_pkg::FUNC_END)
            begin
                for (int i = 0; i < window_fill; i++)
                    emitted.push_back(window[i]);
                window_fill = 0;
            end
            else
            begin
                plen = pattern_width();
                if (window_fill >= plen)
                    window_fill = 0;
                window[window_fill] = it.char_byte;
                window_fill++;
                // drop the oldest byte until the window is a pattern prefix again
                is_prefix = 1'b0;
                while (!is_prefix)
                begin
                    is_prefix = 1'b1;
                    for (int i = 0; i < window_fill; i++)
                        if (window[i] != pattern_word[8*i +: 8])
                            is_prefix = 1'b0;
                    if (!is_prefix)
                    begin
                        emitted.push_back(window[0]);
                        for (int i = 1; i < window_fill; i++)
                            window[i-1] = window[i];
                        window_fill--;
                    end
                end
                if (window_fill == plen)
                begin
                    rlen = (repl_len > 4'd8) ? 8 : int'(repl_len);
                    for (int i = 0; i < rlen; i++)
                        emitted.push_back(repl_word[8*i +: 8]);
                    window_fill = 0;
                end
            end
            foreach (emitted[i])
            begin
                r.out_byte = emitted[i];
                r.last     = (i == emitted.size() - 1);
                expected_bytes.push_back(r);
            end
        endfunction

        function void check_result(sfr_pkg::result_t got);
            sfr_pkg::result_t want;
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: result word with none expected, got byte %02h last %0b",
                         $time, got.out_byte, got.last);
                errors++;
                return;
            end
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte)
            begin
                $display("%0t: out_byte mismatch, expected %02h, got %02h",
                         $time, want.out_byte, got.out_byte);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $display("%0t: last mismatch, expected %0b, got %0b",
                         $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           item_valid;
    logic                           item_ready;
    sfr_pkg::item_t                 item;
    logic                           result_valid;
    logic                           result_ready;
    sfr_pkg::result_t               result;

    replace_scoreboard board = new();
    int                send_idle_pct;
    int                recv_idle_pct;
    int                cycle_count;

    stream_find_and_replace i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        result_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
        if (rst_n && result_valid && result_ready)
            board.check_result(result);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, board.expected_bytes.size());
            $display("tb_stream_find_and_replace: FAIL");
            $finish;
        end
    end

    // valid stays high after acceptance so a following word can go out back to back
    task automatic push_item(input sfr_pkg::item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        board.note_item(it);
    endtask

    task automatic push_char(input logic [7:0] c);
        sfr_pkg::item_t it;
        it.func      = sfr_pkg::FUNC_CHAR;
        it.char_byte = c;
        push_item(it);
    endtask

    task automatic push_end();
        sfr_pkg::item_t it;
        it.func      = sfr_pkg::FUNC_END;
        it.char_byte = 8'($urandom);
        push_item(it);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endtask

    // hold off the sender until every expected word is out and the block has settled
    task automatic wait_idle();
        item_valid <= 1'b0;
        while (board.expected_bytes.size() != 0)
            @(posedge clk);
        repeat (IDLE_GAP) @(posedge clk);
    endtask

    // leaves cfg_we high so writes can go back to back; caller lowers it
    task automatic write_reg(input sfr_pkg::cfg_reg_t idx, input logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        board.load_reg(idx, data);
    endtask

    function automatic logic [63:0] pick_len();
        logic [63:0] w;
        w = {$urandom, $urandom};
        if ($urandom_range(1) == 0)
            w[63:4] = '0;
        case ($urandom_range(5))
            0:       w[3:0] = 4'd0;
            1:       w[3:0] = 4'd8;
            2:       w[3:0] = 4'($urandom_range(9, 15));
            default: w[3:0] = 4'($urandom_range(1, 4));
        endcase
        return w;
    endfunction

    task automatic random_setting();
        logic [63:0] pat;
        logic [63:0] rep;
        logic [7:0]  base;
        int          mode;
        base = 8'($urandom);
        mode = $urandom_range(9);
        // patterns built from two neighboring bytes give repeated prefixes
        for (int i = 0; i < 8; i++)
        begin
            pat[8*i +: 8] = $urandom_range(1) ? base + 8'($urandom_range(1)) : 8'($urandom);
            rep[8*i +: 8] = 8'($urandom);
        end
        if (mode == 0)
            pat = '0;
        else if (mode == 1)
            pat = '1;
        if (mode == 2)
            rep = '1;
        // sometimes only the replacement changes and pending bytes survive
        if ($urandom_range(3) != 0)
        begin
            write_reg(sfr_pkg::REG_PATTERN_BYTES, pat);
            write_reg(sfr_pkg::REG_PATTERN_LENGTH, pick_len());
        end
        write_reg(sfr_pkg::REG_REPLACEMENT_BYTES, rep);
        write_reg(sfr_pkg::REG_REPLACEMENT_LENGTH, pick_len());
        cfg_we <= 1'b0;
    endtask

    // text rich in whole and partial pattern occurrences, with some noise and end words
    task automatic send_text(input int count);
        int sent;
        int plen;
        int pick;
        int k;
        sent = 0;
        while (sent < count)
        begin
            plen = board.pattern_width();
            pick = $urandom_range(99);
            if (pick < 25)
            begin
                k = (pick < 15) ? plen : $urandom_range(plen);
                for (int i = 0; i < k; i++)
                    push_char(board.pattern_word[8*i +: 8]);
                sent += k;
            end
            else
            begin
                if (pick < 65)
                    push_char(board.pattern_word[8*$urandom_range(plen - 1) +: 8]);
                else if (pick < 71)
                    push_end();
                else
                    push_char(8'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= sfr_pkg::REG_PATTERN_BYTES;
        cfg_data      <= '0;
        item_valid    <= 1'b0;
        item          <= '0;
        send_idle_pct = 9;
        recv_idle_pct = 88;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: zero byte pattern, empty replacement deletes it
        push_char(8'h00);
        push_char(8'h41);
        push_end();
        wait_idle();

        write_reg(sfr_pkg::REG_PATTERN_BYTES, 64'h0000_0000_0063_6261);
        write_reg(sfr_pkg::REG_PATTERN_LENGTH, 64'd3);
        write_reg(sfr_pkg::REG_REPLACEMENT_BYTES, 64'h5958);
        write_reg(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'd2);
        cfg_we <= 1'b0;
        push_text("abcababxab");
        push_end();
        push_end();
        // replacement swapped while a prefix is pending
        push_char("a");
        wait_idle();
        write_reg(sfr_pkg::REG_REPLACEMENT_BYTES, 64'h51);
        write_reg(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'd1);
        cfg_we <= 1'b0;
        push_text("bcab");
        // pattern change drops the pending prefix
        wait_idle();
        write_reg(sfr_pkg::REG_PATTERN_LENGTH, 64'd2);
        cfg_we <= 1'b0;
        push_end();
        wait_idle();

        // longest pattern of zero bytes, oversized lengths clamp to eight
        write_reg(sfr_pkg::REG_PATTERN_BYTES, 64'h0);
        write_reg(sfr_pkg::REG_PATTERN_LENGTH, 64'd15);
        write_reg(sfr_pkg::REG_REPLACEMENT_BYTES, '1);
        write_reg(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'd15);
        cfg_we <= 1'b0;
        repeat (8) push_char(8'h00);
        wait_idle();

        // zero pattern length acts as one
        write_reg(sfr_pkg::REG_PATTERN_BYTES, 64'hFF);
        write_reg(sfr_pkg::REG_PATTERN_LENGTH, 64'd0);
        write_reg(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'd0);
        cfg_we <= 1'b0;
        push_char(8'hFF);
        push_char(8'h00);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 88 : 0;
            recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 9 : 0;
            repeat (2)
            begin
                wait_idle();
                random_setting();
                send_text(56);
            end
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (board.errors == 0 && board.expected_bytes.size() == 0)
            $display("tb_stream_find_and_replace: PASS");
        else
            $display("tb_stream_find_and_replace: FAIL");
        $finish;
    end

endmodule
